// File: rtl/scta_pkg.sv
// scancode_to_ascii_fifo package: buffer sizing, scancode constants,
// the set 1 key table and the memory request struct.
// no dependencies; imported by every module of the block except scta_ram
package scta_pkg;

  localparam int DEPTH      = 256;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CHAR_W     = 7;
  localparam int CODE_W     = 8;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [CODE_W-1:0] code_t;

  localparam ptr_t LAST_PTR = PTR_W'(DEPTH - 1);
  localparam ptr_t PTR_ONE  = PTR_W'(1);

  localparam code_t SC_ACK      = 8'hFA;
  localparam code_t SC_NACK     = 8'hFE;
  localparam code_t SC_SELFTEST = 8'hAA;
  localparam code_t SC_RELEASE  = 8'h80;

  localparam logic FUNC_EVENT = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef struct packed {
    logic  wr_en;
    ptr_t  wr_addr;
    char_t wr_data;
    logic  rd_en;
    ptr_t  rd_addr;
  } ram_req_t;

  function automatic ptr_t advance(input ptr_t p);
    return (p == LAST_PTR) ? '0 : p + PTR_ONE;
  endfunction

  // set 1 make code to ascii, zero for keys without a character
  function automatic char_t key_map(input logic [6:0] code);
    char_t c;
    case (code)
      7'd1:    c = 7'h1B;
      7'd2:    c = 7'h31;
      7'd3:    c = 7'h32;
      7'd4:    c = 7'h33;
      7'd5:    c = 7'h34;
      7'd6:    c = 7'h35;
      7'd7:    c = 7'h36;
      7'd8:    c = 7'h37;
      7'd9:    c = 7'h38;
      7'd10:   c = 7'h39;
      7'd11:   c = 7'h30;
      7'd12:   c = 7'h2D;
      7'd13:   c = 7'h3D;
      7'd14:   c = 7'h08;
      7'd15:   c = 7'h09;
      7'd16:   c = 7'h71;
      7'd17:   c = 7'h77;
      7'd18:   c = 7'h65;
      7'd19:   c = 7'h72;
      7'd20:   c = 7'h74;
      7'd21:   c = 7'h79;
      7'd22:   c = 7'h75;
      7'd23:   c = 7'h69;
      7'd24:   c = 7'h6F;
      7'd25:   c = 7'h70;
      7'd26:   c = 7'h5B;
      7'd27:   c = 7'h5D;
      7'd28:   c = 7'h0A;
      7'd30:   c = 7'h61;
      7'd31:   c = 7'h73;
      7'd32:   c = 7'h64;
      7'd33:   c = 7'h66;
      7'd34:   c = 7'h67;
      7'd35:   c = 7'h68;
      7'd36:   c = 7'h6A;
      7'd37:   c = 7'h6B;
      7'd38:   c = 7'h6C;
      7'd39:   c = 7'h3B;
      7'd40:   c = 7'h27;
      7'd41:   c = 7'h60;
      7'd43:   c = 7'h5C;
      7'd44:   c = 7'h7A;
      7'd45:   c = 7'h78;
      7'd46:   c = 7'h63;
      7'd47:   c = 7'h76;
      7'd48:   c = 7'h62;
      7'd49:   c = 7'h6E;
      7'd50:   c = 7'h6D;
      7'd51:   c = 7'h2C;
      7'd52:   c = 7'h2E;
      7'd53:   c = 7'h2F;
      7'd55:   c = 7'h2A;
      7'd57:   c = 7'h20;
      7'd71:   c = 7'h37;
      7'd72:   c = 7'h38;
      7'd73:   c = 7'h39;
      7'd74:   c = 7'h2D;
      7'd75:   c = 7'h34;
      7'd76:   c = 7'h35;
      7'd77:   c = 7'h36;
      7'd78:   c = 7'h2B;
      7'd79:   c = 7'h31;
      7'd80:   c = 7'h32;
      7'd81:   c = 7'h33;
      7'd82:   c = 7'h30;
      7'd83:   c = 7'h2E;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/scta_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
module scta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/scta_ctrl.sv
// scancode filter, key lookup, ring pointers and result register
// depends on scta_pkg; drives the character ram through ram_req_t
module scta_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic              data_ready,
  input  scta_pkg::code_t   scancode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              read_ok,
  output scta_pkg::char_t   ch,
  output logic              char_added,
  output logic              overflow,
  output scta_pkg::ram_req_t ram_req,
  input  scta_pkg::char_t   ram_rdata
);
  import scta_pkg::*;

  ptr_t  wp_r, wp_nxt;
  ptr_t  rp_r, rp_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic  read_ok_r, read_ok_nxt;
  logic  added_r, added_nxt;
  logic  ovf_r, ovf_nxt;

  logic  accept;
  logic  is_read;
  logic  empty;
  logic  full;
  ptr_t  wp_adv;
  char_t mapped;
  logic  eligible;
  logic  pop;
  logic  push;
  logic  drop;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_read  = (func == FUNC_READ);
  assign wp_adv   = advance(wp_r);
  assign empty    = (wp_r == rp_r);
  assign full     = (wp_adv == rp_r);
  assign mapped   = key_map(scancode[6:0]);

  assign eligible = data_ready && (scancode != SC_ACK) && (scancode != SC_NACK)
                    && (scancode != SC_SELFTEST) && ((scancode & SC_RELEASE) == '0)
                    && (mapped != '0);

  assign pop  = accept && is_read && !empty;
  assign push = accept && !is_read && eligible && !full;
  assign drop = accept && !is_read && eligible && full;

  always_comb begin
    ram_req.wr_en   = push;
    ram_req.wr_addr = wp_r;
    ram_req.wr_data = mapped;
    ram_req.rd_en   = pop;
    ram_req.rd_addr = rp_r;
  end

  always_comb begin
    wp_nxt        = push ? wp_adv : wp_r;
    rp_nxt        = pop ? advance(rp_r) : rp_r;
    out_valid_nxt = accept ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    read_ok_nxt   = accept ? pop : read_ok_r;
    added_nxt     = accept ? push : added_r;
    ovf_nxt       = accept ? drop : ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    read_ok_r <= read_ok_nxt;
    added_r   <= added_nxt;
    ovf_r     <= ovf_nxt;
  end

  assign out_valid  = out_valid_r;
  assign read_ok    = read_ok_r;
  assign ch         = read_ok_r ? ram_rdata : '0;
  assign char_added = added_r;
  assign overflow   = ovf_r;

endmodule

// File: rtl/scancode_to_ascii_fifo.sv
// Set 1 keyboard scancode to ascii converter with a character ring buffer. Each
// input transaction is a key event (in_tuser 0) or a non-blocking read (in_tuser 1);
// each gives exactly one result transaction, in the cycle after it is accepted, and a
// new transaction can be taken every cycle while the result side keeps up. The
// buffer holds DEPTH-1 characters in one ram with a write port for pushes and a
// registered read port for pops; a pop's character comes out of that port in the
// same cycle as its result flags. Acks, nacks, self-test codes, releases and keys
// without a character give an all-zero result. No clearing pass is needed after reset.
// depends on scta_pkg, scta_ram and scta_ctrl
module scancode_to_ascii_fifo (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [scta_pkg::IN_DATA_W-1:0]     in_tdata,  // data_ready, scancode[7:0]
  input  logic                               in_tuser,  // func
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [scta_pkg::OUT_DATA_W-1:0]    out_tdata  // read_ok, ch[6:0], char_added, overflow
);
  import scta_pkg::*;

  ram_req_t ram_req;
  char_t    ram_rdata;
  logic     read_ok;
  char_t    ch;
  logic     char_added;
  logic     overflow;

  scta_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .func       (in_tuser),
    .data_ready (in_tdata[0]),
    .scancode   (in_tdata[8:1]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .read_ok    (read_ok),
    .ch         (ch),
    .char_added (char_added),
    .overflow   (overflow),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata)
  );

  scta_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rdata)
  );

  assign out_tdata = {6'b0, overflow, char_added, ch, read_ok};

endmodule

// File: rtl/scta_checker.sv
// port-level checks for scancode_to_ascii_fifo, attached by bind
// depends on scta_pkg
module scta_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [scta_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [scta_pkg::OUT_DATA_W-1:0] out_tdata
);
  import scta_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0({out_tdata[0], out_tdata[8], out_tdata[9]}))
    else $error("more than one result flag set");

  a_ch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[7:1] == '0)
    else $error("character without a pop");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted transaction gave no result");

  a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_EVENT) && !in_tdata[0]
    |=> out_tdata == '0)
    else $error("ignored event gave a nonzero result");

endmodule

bind scancode_to_ascii_fifo scta_checker u_scta_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/tb_scancode_to_ascii_fifo.sv
// testbench for scancode_to_ascii_fifo: directed table plus random typing/reading bursts, every
// result checked against a typed row or a behavioral scancode-to-ascii ring buffer predictor
// depends on scta_pkg and the scancode_to_ascii_fifo rtl
module tb_scancode_to_ascii_fifo;
  import scta_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int FILL_EXTRA   = 15;
  localparam int PHASE_ITEMS  = 300;
  localparam int TAIL_CYCLES  = 8;
  localparam int MAX_REPORTS  = 20;

  typedef struct {
    logic  read_ok;
    char_t ch;
    logic  char_added;
    logic  overflow;
  } key_result_t;

  typedef struct {
    logic        func;
    logic        data_ready;
    code_t       code;
    bit          typed;
    key_result_t result;
  } key_row_t;

  typedef enum int {MODE_TYPING, MODE_READING, MODE_MIXED} burst_mode_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tuser   = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;

  // set 1 make code to ascii, zero where the key has no character
  char_t ascii_of [128] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  char_t       char_ring [DEPTH];
  int          ring_wr = 0;
  int          ring_rd = 0;
  key_result_t awaited_results [$];
  key_row_t    directed_rows [$];
  code_t       mapped_codes [$];
  key_result_t blank_result = '{default: '0};

  int errors       = 0;
  int cycles       = 0;
  int gap_pct      = 0;
  int stall_pct    = 0;
  int hold_reqs    = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int useful_items = 0;
  int n_added      = 0;
  int n_dropped    = 0;
  int n_popped     = 0;
  int n_empty      = 0;
  int n_ignored    = 0;

  scancode_to_ascii_fifo i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
      $display("** scancode_to_ascii_fifo: FAILED **");
      $finish;
    end
  end

  // result side: random stalls plus the long hold-off on request
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic key_result_t ascii_fifo_step(logic func, logic ready, code_t code);
    key_result_t r;
    char_t       c;
    int          nxt;
    r = '{default: '0};
    if (func == FUNC_READ) begin
      if (ring_wr != ring_rd) begin
        r.read_ok = 1'b1;
        r.ch      = char_ring[ring_rd];
        ring_rd   = (ring_rd + 1) % DEPTH;
      end
    end else if (ready && code != SC_ACK && code != SC_NACK && code != SC_SELFTEST &&
                 (code & SC_RELEASE) == '0) begin
      c = ascii_of[code[6:0]];
      if (c != '0) begin
        nxt = (ring_wr + 1) % DEPTH;
        if (nxt != ring_rd) begin
          char_ring[ring_wr] = c;
          ring_wr            = nxt;
          r.char_added       = 1'b1;
        end else begin
          r.overflow = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors = errors + 1;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    key_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        errors = errors + 1;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected nothing, got %h", $time, out_tdata);
      end else begin
        want = awaited_results.pop_front();
        check_field("read_ok", int'(want.read_ok), int'(out_tdata[0]));
        check_field("ch", int'(want.ch), int'(out_tdata[7:1]));
        check_field("char_added", int'(want.char_added), int'(out_tdata[8]));
        check_field("overflow", int'(want.overflow), int'(out_tdata[9]));
      end
    end
  end

  task automatic send_item(logic func, logic ready, code_t code, bit typed,
                           key_result_t typed_res);
    key_result_t want;
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= IN_DATA_W'({code, ready});
    do @(posedge clk); while (!in_tready);
    want = ascii_fifo_step(func, ready, code);
    if (func == FUNC_READ) begin
      useful_items = useful_items + 1;
      if (want.read_ok) n_popped = n_popped + 1;
      else n_empty = n_empty + 1;
    end else if (want.char_added || want.overflow) begin
      useful_items = useful_items + 1;
      if (want.char_added) n_added = n_added + 1;
      else n_dropped = n_dropped + 1;
    end else begin
      n_ignored = n_ignored + 1;
    end
    awaited_results.push_back(typed ? typed_res : want);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  function automatic void add_row(logic func, logic ready, code_t code, bit typed,
                                  logic r_ok, char_t ch, logic added, logic ovf);
    key_row_t row;
    row.func       = func;
    row.data_ready = ready;
    row.code       = code;
    row.typed      = typed;
    row.result     = '{r_ok, ch, added, ovf};
    directed_rows.push_back(row);
  endfunction

  function automatic code_t any_mapped();
    return mapped_codes[$urandom_range(mapped_codes.size() - 1)];
  endfunction

  function automatic code_t ignored_code();
    case ($urandom_range(3))
      0:       return SC_ACK;
      1:       return SC_NACK;
      2:       return SC_SELFTEST;
      default: return SC_RELEASE | code_t'($urandom_range(127));
    endcase
  endfunction

  task automatic random_item(burst_mode_t mode);
    int    roll;
    logic  func;
    logic  ready;
    code_t code;
    roll = $urandom_range(99);
    case (mode)
      MODE_TYPING:  func = (roll < 10) ? FUNC_READ : FUNC_EVENT;
      MODE_READING: func = (roll < 85) ? FUNC_READ : FUNC_EVENT;
      default:      func = (roll < 50) ? FUNC_READ : FUNC_EVENT;
    endcase
    ready = ($urandom_range(99) >= 5);
    roll  = $urandom_range(99);
    if (func == FUNC_READ || roll >= 88) code = code_t'($urandom_range(255));
    else if (roll < 75) code = any_mapped();
    else code = ignored_code();
    send_item(func, ready, code, 1'b0, blank_result);
  endtask

  task automatic run_phase(int gap, int stall, bit with_hold);
    int          start;
    int          burst_left;
    burst_mode_t mode;
    gap_pct    = gap;
    stall_pct  = stall;
    start      = useful_items;
    burst_left = 0;
    mode       = MODE_MIXED;
    if (with_hold) hold_reqs = hold_reqs + 1;
    while (useful_items - start < PHASE_ITEMS) begin
      if (burst_left == 0) begin
        mode       = burst_mode_t'($urandom_range(2));
        burst_left = $urandom_range(60, 20);
      end
      random_item(mode);
      burst_left = burst_left - 1;
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < 128; i++)
      if (ascii_of[i] != '0) mapped_codes.push_back(code_t'(i));

    // after reset, ignored events, single push and pop, empty reads, then further pushes and pops
    add_row(FUNC_READ,  1'b0, 8'h00,       1'b1, 1'b0, 7'h00, 1'b0, 1'b0);
    add_row(FUNC_EVENT, 1'b0, 8'h1E,       1'b1, 1'b0, 7'h00, 1'b0, 1'b0);
    add_row(FUNC_EVENT, 1'b1, SC_ACK,      1'b1, 1'b0, 7'h00, 1'b0, 1'b0);
    add_row(FUNC_EVENT, 1'b1, SC_NACK,     1'b1, 1'b0, 7'h00, 1'b0, 1'b0);
    add_row(FUNC_EVENT, 1'b1, SC_SELFTEST, 1'b1, 1'b0, 7'h00, 1'b0, 1'b0);
    add_row(FUNC_EVENT, 1'b1, 8'h9E,       1'b1, 1'b0, 7'h00, 1'b0, 1'b0);
    add_row(FUNC_EVENT, 1'b1, 8'hFF,       1'b1, 1'b0, 7'h00, 1'b0, 1'b0);
    add_row(FUNC_EVENT, 1'b1, 8'h00,       1'b1, 1'b0, 7'h00, 1'b0, 1'b0);
    add_row(FUNC_EVENT, 1'b1, 8'h7F,       1'b1, 1'b0, 7'h00, 1'b0, 1'b0);
    add_row(FUNC_EVENT, 1'b1, 8'h54,       1'b1, 1'b0, 7'h00, 1'b0, 1'b0);
    add_row(FUNC_EVENT, 1'b1, 8'h1E,       1'b1, 1'b0, 7'h00, 1'b1, 1'b0);
    add_row(FUNC_READ,  1'b0, 8'h00,       1'b1, 1'b1, 7'h61, 1'b0, 1'b0);
    add_row(FUNC_READ,  1'b1, 8'hFF,       1'b1, 1'b0, 7'h00, 1'b0, 1'b0);
    add_row(FUNC_EVENT, 1'b1, 8'h01,       1'b1, 1'b0, 7'h00, 1'b1, 1'b0);
    add_row(FUNC_EVENT, 1'b1, 8'h53,       1'b1, 1'b0, 7'h00, 1'b1, 1'b0);
    add_row(FUNC_EVENT, 1'b1, 8'h39,       1'b1, 1'b0, 7'h00, 1'b1, 1'b0);
    add_row(FUNC_READ,  1'b1, 8'hFF,       1'b0, 1'b0, 7'h00, 1'b0, 1'b0);
    add_row(FUNC_READ,  1'b0, 8'h80,       1'b0, 1'b0, 7'h00, 1'b0, 1'b0);
    add_row(FUNC_READ,  1'b1, 8'h55,       1'b0, 1'b0, 7'h00, 1'b0, 1'b0);
    add_row(FUNC_READ,  1'b0, 8'hAA,       1'b1, 1'b0, 7'h00, 1'b0, 1'b0);
    add_row(FUNC_EVENT, 1'b1, 8'h1C,       1'b0, 1'b0, 7'h00, 1'b0, 1'b0);
    add_row(FUNC_EVENT, 1'b0, SC_ACK,      1'b1, 1'b0, 7'h00, 1'b0, 1'b0);
    add_row(FUNC_READ,  1'b1, 8'h00,       1'b0, 1'b0, 7'h00, 1'b0, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].func, directed_rows[i].data_ready, directed_rows[i].code,
                directed_rows[i].typed, directed_rows[i].result);
    wait_drained();

    // fill past full to force drops, then drain past empty
    gap_pct   = 0;
    stall_pct = 0;
    repeat (DEPTH + FILL_EXTRA)
      send_item(FUNC_EVENT, 1'b1, any_mapped(), 1'b0, blank_result);
    repeat (DEPTH + FILL_EXTRA)
      send_item(FUNC_READ, 1'($urandom_range(1)), code_t'($urandom_range(255)), 1'b0,
                blank_result);
    wait_drained();

    run_phase(0, 0, 1'b1);
    run_phase(59, 0, 1'b0);
    run_phase(0, 59, 1'b0);
    run_phase(9, 9, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d checked transactions: %0d characters queued, %0d dropped full,",
             useful_items, n_added, n_dropped);
    $display("%0d popped, %0d empty reads, %0d ignored events, %0d mismatches in %0d cycles",
             n_popped, n_empty, n_ignored, errors, cycles);
    if (errors == 0) begin
      $display("** scancode_to_ascii_fifo: PASSED **");
    end else begin
      $display("** scancode_to_ascii_fifo: FAILED **");
    end
    $finish;
  end

endmodule
